/* rtl/dsc_pkg.sv */
// Shared types, constants and the decimal split for the dimmer switch controller.
// Used by every module in rtl/. Has no dependencies of its own.
package dsc_pkg;

	// Config register indexes
	localparam logic [1:0] CFG_MAX_LEVEL     = 2'd0;
	localparam logic [1:0] CFG_RELEASE_LIMIT = 2'd1;
	localparam logic [1:0] CFG_HOLD_LIMIT    = 2'd2;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 10;

	// Reset values of the config registers
	localparam logic [7:0] MAX_LEVEL_RST     = 8'd100;
	localparam logic [7:0] RELEASE_LIMIT_RST = 8'd20;
	localparam logic [9:0] HOLD_LIMIT_RST    = 10'd400;

	// Opcodes
	localparam logic [1:0] OP_START = 2'd0;
	localparam logic [1:0] OP_STEP  = 2'd1;
	localparam logic [1:0] OP_TICK  = 2'd2;

	// Counter ceilings
	localparam logic [10:0] HOLD_MAX    = 11'd2047;
	localparam logic [8:0]  RELEASE_MAX = 9'd511;

	// Command characters
	localparam logic [7:0] CH_L     = 8'h4C;
	localparam logic [7:0] CH_A     = 8'h41;
	localparam logic [7:0] CH_B     = 8'h42;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NL    = 8'h0A;

	// Default depth of the command queue
	localparam int QUEUE_DEPTH = 4;

	// One queued command pair: level to send plus status after the item
	typedef struct packed {
		logic [7:0] value;
		logic       relay;
		logic       is_on;
	} cmd_t;

	// Decimal form of an 8-bit value
	typedef struct packed {
		logic [1:0] hund;
		logic [3:0] tens;
		logic [3:0] ones;
		logic       has_h;
		logic       has_t;
	} digits_t;

	function automatic digits_t dsc_digits(input logic [7:0] v);
		digits_t    d;
		logic [7:0] r;
		logic [3:0] t;
		d.has_h = (v >= 8'd100);
		d.has_t = (v >= 8'd10);
		if (v >= 8'd200) begin
			d.hund = 2'd2;
			r      = v - 8'd200;
		end else if (v >= 8'd100) begin
			d.hund = 2'd1;
			r      = v - 8'd100;
		end else begin
			d.hund = 2'd0;
			r      = v;
		end
		// r < 100: count the tens thresholds it reaches
		t = 4'd0;
		for (int k = 1; k <= 9; k++) begin
			if (r >= 8'(10 * k))
				t = t + 4'd1;
		end
		d.tens = t;
		d.ones = 4'(r - 8'(t) * 8'd10);
		return d;
	endfunction

endpackage

/* rtl/dsc_front.sv */
// Front end: takes input words, holds the config registers and the controller state.
// Pushes one command pair per sending event into the queue. Depends on dsc_pkg.
module dsc_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [dsc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [dsc_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           item_valid,
	output logic                           item_stall,
	input  logic [1:0]                     opcode,
	input  logic                           direction,
	input  logic                           button_pressed,
	input  logic                           q_full,
	output logic                           push,
	output dsc_pkg::cmd_t                  push_cmd
);
	import dsc_pkg::*;

	logic [7:0]  max_level_q;
	logic [7:0]  release_limit_q;
	logic [9:0]  hold_limit_q;

	logic [7:0]  level_q, level_d;
	logic        on_q, on_d;
	logic        relay_q, relay_d;
	logic [10:0] hold_q, hold_d, hold_inc;
	logic [8:0]  rel_q, rel_d, rel_inc;
	logic        send;
	logic [7:0]  send_val;
	logic        accept;

	assign item_stall = q_full;
	assign accept     = item_valid && !item_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_level_q     <= MAX_LEVEL_RST;
			release_limit_q <= RELEASE_LIMIT_RST;
			hold_limit_q    <= HOLD_LIMIT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_MAX_LEVEL:     max_level_q     <= cfg_data[7:0];
				CFG_RELEASE_LIMIT: release_limit_q <= cfg_data[7:0];
				CFG_HOLD_LIMIT:    hold_limit_q    <= cfg_data[9:0];
				default: ;
			endcase
		end
	end

	assign hold_inc = (hold_q != HOLD_MAX) ? hold_q + 11'd1 : hold_q;
	assign rel_inc  = (rel_q != RELEASE_MAX) ? rel_q + 9'd1 : rel_q;

	always_comb begin
		level_d  = level_q;
		on_d     = on_q;
		relay_d  = relay_q;
		hold_d   = hold_q;
		rel_d    = rel_q;
		send     = 1'b0;
		send_val = level_q;
		unique case (opcode)
			OP_START: begin
				if (button_pressed)
					relay_d = 1'b1;
				on_d = 1'b1;
				send = 1'b1;
			end
			OP_STEP: begin
				if (direction)
					level_d = (level_q >= max_level_q) ? max_level_q : level_q + 8'd1;
				else if (level_q != 8'd0)
					level_d = level_q - 8'd1;
				send     = (level_d != level_q);
				send_val = level_d;
			end
			OP_TICK: begin
				if (on_q) begin
					if (button_pressed)
						hold_d = hold_inc;
					else
						rel_d = rel_inc;
					if (rel_d > {1'b0, release_limit_q}) begin
						hold_d = 11'd0;
						rel_d  = 9'd0;
					end
					if (hold_d > {1'b0, hold_limit_q}) begin
						on_d     = 1'b0;
						send     = 1'b1;
						send_val = 8'd0;
						hold_d   = 11'd0;
						rel_d    = 9'd0;
						relay_d  = 1'b0;
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= 8'd0;
			on_q    <= 1'b0;
			relay_q <= 1'b0;
			hold_q  <= 11'd0;
			rel_q   <= 9'd0;
		end else if (accept) begin
			level_q <= level_d;
			on_q    <= on_d;
			relay_q <= relay_d;
			hold_q  <= hold_d;
			rel_q   <= rel_d;
		end
	end

	assign push           = accept && send;
	assign push_cmd.value = send_val;
	assign push_cmd.relay = relay_d;
	assign push_cmd.is_on = on_d;

endmodule

/* rtl/dsc_queue.sv */
// Short command queue between front and back, in flip-flops.
// Depends on dsc_pkg for the entry type.
module dsc_queue #(
	parameter int DEPTH = dsc_pkg::QUEUE_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  dsc_pkg::cmd_t push_cmd,
	input  logic          pop,
	output dsc_pkg::cmd_t head,
	output logic          full,
	output logic          not_empty
);
	import dsc_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

	cmd_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] cnt_q;

	assign full      = (cnt_q == CNT_W'(DEPTH));
	assign not_empty = (cnt_q != '0);
	assign head      = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= (wr_q == LAST) ? '0 : wr_q + PTR_W'(1);
			if (pop)
				rd_q <= (rd_q == LAST) ? '0 : rd_q + PTR_W'(1);
			if (push && !pop)
				cnt_q <= cnt_q + CNT_W'(1);
			else if (pop && !push)
				cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	a_no_overfill: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full)) else $error("queue push while full");
	a_no_underrun: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && !not_empty)) else $error("queue pop while empty");

endmodule

/* rtl/dsc_back.sv */
// Back end: turns queued command pairs into ASCII words, one per cycle when not stalled,
// through an output register. Depends on dsc_pkg.
module dsc_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          not_empty,
	input  dsc_pkg::cmd_t head,
	output logic          pop,
	output logic          tx_valid,
	input  logic          tx_stall,
	output logic [7:0]    tx_byte,
	output logic          last_byte,
	output logic          relay_on,
	output logic          powered_on
);
	import dsc_pkg::*;

	localparam logic [2:0] P_L     = 3'd0;
	localparam logic [2:0] P_LAMP  = 3'd1;
	localparam logic [2:0] P_COLON = 3'd2;
	localparam logic [2:0] P_HUND  = 3'd3;
	localparam logic [2:0] P_TENS  = 3'd4;
	localparam logic [2:0] P_ONES  = 3'd5;
	localparam logic [2:0] P_NL    = 3'd6;

	logic       busy_q;
	logic       lamp_q;
	logic [2:0] pos_q, pos_nx;
	digits_t    dig_q;
	logic       relay_q, on_q;

	logic       out_ready, emit, done;
	logic [7:0] byte_cur;

	logic       tx_valid_q;
	logic [7:0] tx_byte_q;
	logic       last_q, relay_out_q, on_out_q;

	assign out_ready = !tx_valid_q || !tx_stall;
	assign emit      = busy_q && out_ready;
	assign done      = emit && lamp_q && (pos_q == P_NL);
	assign pop       = not_empty && (!busy_q || done);

	always_comb begin
		unique case (pos_q)
			P_L:     byte_cur = CH_L;
			P_LAMP:  byte_cur = lamp_q ? CH_B : CH_A;
			P_COLON: byte_cur = CH_COLON;
			P_HUND:  byte_cur = CH_ZERO + {6'd0, dig_q.hund};
			P_TENS:  byte_cur = CH_ZERO + {4'd0, dig_q.tens};
			P_ONES:  byte_cur = CH_ZERO + {4'd0, dig_q.ones};
			P_NL:    byte_cur = CH_NL;
			default: byte_cur = CH_NL;
		endcase
	end

	// Leading zeros are skipped straight after the colon
	always_comb begin
		unique case (pos_q)
			P_L:     pos_nx = P_LAMP;
			P_LAMP:  pos_nx = P_COLON;
			P_COLON: pos_nx = dig_q.has_h ? P_HUND : (dig_q.has_t ? P_TENS : P_ONES);
			P_HUND:  pos_nx = P_TENS;
			P_TENS:  pos_nx = P_ONES;
			P_ONES:  pos_nx = P_NL;
			P_NL:    pos_nx = P_L;
			default: pos_nx = P_L;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			lamp_q <= 1'b0;
			pos_q  <= P_L;
		end else if (pop) begin
			busy_q <= 1'b1;
			lamp_q <= 1'b0;
			pos_q  <= P_L;
		end else if (done) begin
			busy_q <= 1'b0;
		end else if (emit) begin
			pos_q <= pos_nx;
			if (pos_q == P_NL)
				lamp_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			dig_q   <= dsc_digits(head.value);
			relay_q <= head.relay;
			on_q    <= head.is_on;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			tx_valid_q <= 1'b0;
		else if (out_ready)
			tx_valid_q <= emit;
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			tx_byte_q   <= byte_cur;
			last_q      <= lamp_q && (pos_q == P_NL);
			relay_out_q <= relay_q;
			on_out_q    <= on_q;
		end
	end

	assign tx_valid   = tx_valid_q;
	assign tx_byte    = tx_byte_q;
	assign last_byte  = last_q;
	assign relay_on   = relay_out_q;
	assign powered_on = on_out_q;

	a_hund_needed: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && pos_q == P_HUND) |-> dig_q.has_h) else $error("hundreds digit sent for v<100");
	a_tens_needed: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && pos_q == P_TENS) |-> dig_q.has_t) else $error("tens digit sent for v<10");
	a_digit_order: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && dig_q.has_h) |-> dig_q.has_t) else $error("inconsistent digit flags");

endmodule

/* rtl/dimmer_switch_controller_unit.sv */
// Lamp dimmer controller with long-press power-off; top level of front, queue and back.
// Depends on dsc_pkg, dsc_front, dsc_queue and dsc_back.
// Path to tx_*: queue entry, back-end load registers, then the output register.
// Throughput: one input word per cycle while the queue has room; unless stalled, the back end
//   sends one byte per cycle, 10 to 14 per pair, so sustained rate is set by the serialiser.
// Reset: arst_n clears level, power, relay, counters, queue and output valid; config regs reload.
module dimmer_switch_controller_unit #(
	parameter int QUEUE_DEPTH = dsc_pkg::QUEUE_DEPTH
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// config write port
	input  logic                           cfg_we,
	input  logic [dsc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [dsc_pkg::CFG_DATA_W-1:0] cfg_data,
	// input words
	input  logic                           item_valid,
	output logic                           item_stall,
	input  logic [1:0]                     opcode,
	input  logic                           direction,
	input  logic                           button_pressed,
	// output words
	output logic                           tx_valid,
	input  logic                           tx_stall,
	output logic [7:0]                     tx_byte,
	output logic                           last_byte,
	output logic                           relay_on,
	output logic                           powered_on
);
	import dsc_pkg::*;

	// Front -> queue
	logic push;
	cmd_t push_cmd;
	logic q_full;

	// Queue -> back
	cmd_t head;
	logic not_empty;
	logic pop;

	// Front end: decodes the opcode combinationally and registers the new controller state,
	// so words can arrive back to back. It stalls only when the queue is full.
	dsc_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.item_valid     (item_valid),
		.item_stall     (item_stall),
		.opcode         (opcode),
		.direction      (direction),
		.button_pressed (button_pressed),
		.q_full         (q_full),
		.push           (push),
		.push_cmd       (push_cmd)
	);

	// Each entry is one lamp A + lamp B command pair with the status
	// snapshot to be shown alongside its bytes.
	dsc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_cmd  (push_cmd),
		.pop       (pop),
		.head      (head),
		.full      (q_full),
		.not_empty (not_empty)
	);

	// Back end: splits the level into decimal digits on load and walks the
	// byte sequence; the next entry is loaded in the cycle the last byte enters the output register.
	dsc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.not_empty  (not_empty),
		.head       (head),
		.pop        (pop),
		.tx_valid   (tx_valid),
		.tx_stall   (tx_stall),
		.tx_byte    (tx_byte),
		.last_byte  (last_byte),
		.relay_on   (relay_on),
		.powered_on (powered_on)
	);

endmodule
